// ===== sv/ulars_pkg.sv =====
// ----------------------------------------------------------------------------
// ulars_pkg: shared types and constants of the UART link ack/retry sequencer
// Word formats of both channels, the event passed from the receive front
// to the sender back, frame kinds, sender steps and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package ulars_pkg;

	// Input word: one time-base tick with an optional received byte.
	typedef struct packed {
		logic       byte_valid;
		logic [7:0] byte_value;
		logic       tx_busy;
		logic       send_request;
	} in_word_t;

	// Result word: one per tick.
	typedef struct packed {
		logic       send_frame;
		logic       send_done;
		logic [2:0] frame_kind;
		logic [7:0] frame_length;
	} out_word_t;

	// Kind of a classified frame.
	typedef enum logic [2:0] {
		KIND_NONE  = 3'd0,
		KIND_ACK   = 3'd1,
		KIND_NACK  = 3'd2,
		KIND_NEW   = 3'd3,
		KIND_OTHER = 3'd4
	} kind_t;

	// Steps of the stop-and-wait sender.
	typedef enum logic [2:0] {
		STEP_IDLE  = 3'd0,
		STEP_WAIT  = 3'd1,
		STEP_GUARD = 3'd2,
		STEP_SEND  = 3'd3,
		STEP_DRAIN = 3'd4,
		STEP_REPLY = 3'd5
	} step_t;

	// Event handed from the front to the back for one tick.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] flen;
		logic       receiving;
		logic       tx_busy;
		logic       send_request;
	} link_evt_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_GAP     = 2'd0;
	localparam logic [1:0] CFG_GUARD   = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT = 2'd2;

	localparam logic [15:0] GAP_RESET     = 16'd300;
	localparam logic [15:0] GUARD_RESET   = 16'd400;
	localparam logic [15:0] TIMEOUT_RESET = 16'd10000;

	// Characters of the reply frames.
	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_K = 8'h4B;
	localparam logic [7:0] CHAR_N = 8'h4E;
	localparam logic [7:0] CHAR_W = 8'h57;

	// Depth of the event queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

endpackage

`default_nettype wire

// ===== sv/ulars_front.sv =====
// ----------------------------------------------------------------------------
// ulars_front: receive front end
// Counts received bytes, keeps the first four, runs the idle gap timer and
// classifies a frame once the gap expires. Emits one event word per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module ulars_front #(
	parameter int COUNT_WIDTH = 8,
	parameter int TIMER_WIDTH = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  ulars_pkg::in_word_t  item,
	input  wire [15:0]           gap_ticks,
	output ulars_pkg::link_evt_t evt
);
	import ulars_pkg::*;

	localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
	localparam int EXT_W = COUNT_WIDTH + 8;

	logic [7:0]             head_q [4];
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   receiving_q;
	logic [TIMER_WIDTH-1:0] gap_q;

	logic [TIMER_WIDTH-1:0] gap_next;
	logic                   gap_done;
	kind_t                  kind;
	logic [EXT_W-1:0]       count_ext;
	logic [7:0]             flen_sat;

	// Gap timer advance and expiry test.
	always_comb begin
		gap_next = (gap_q == '1) ? gap_q : gap_q + 1'b1;
		gap_done = (CMP_W'(gap_next) >= CMP_W'(gap_ticks)) || (gap_next == '1);
	end

	// Frame classification from the kept head bytes and the byte count.
	always_comb begin
		if (count_q == COUNT_WIDTH'(3) && head_q[0] == CHAR_A &&
				head_q[1] == CHAR_C && head_q[2] == CHAR_K) begin
			kind = KIND_ACK;
		end else if (count_q == COUNT_WIDTH'(4) && head_q[0] == CHAR_N &&
				head_q[1] == CHAR_A && head_q[2] == CHAR_C && head_q[3] == CHAR_K) begin
			kind = KIND_NACK;
		end else if (count_q > COUNT_WIDTH'(5) && head_q[1] == CHAR_W) begin
			kind = KIND_NEW;
		end else begin
			kind = KIND_OTHER;
		end
	end

	// Frame length saturates at 255.
	always_comb begin
		count_ext = EXT_W'(count_q);
		flen_sat  = (count_ext > EXT_W'(255)) ? 8'hFF : count_ext[7:0];
	end

	// Event word for the back end.
	always_comb begin
		evt.kind         = KIND_NONE;
		evt.flen         = 8'd0;
		evt.receiving    = receiving_q;
		evt.tx_busy      = item.tx_busy;
		evt.send_request = item.send_request;
		if (item.byte_valid) begin
			evt.receiving = 1'b1;
		end else if (receiving_q && gap_done) begin
			evt.kind      = kind;
			evt.flen      = flen_sat;
			evt.receiving = 1'b0;
		end
	end

	// Receiver state update on each accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				head_q[i] <= 8'd0;
			end
			count_q     <= '0;
			receiving_q <= 1'b0;
			gap_q       <= '0;
		end else if (accept) begin
			if (item.byte_valid) begin
				if (count_q < COUNT_WIDTH'(4)) begin
					head_q[count_q[1:0]] <= item.byte_value;
				end
				if (count_q != '1) begin
					count_q <= count_q + 1'b1;
				end
				receiving_q <= 1'b1;
				gap_q       <= '0;
			end else if (receiving_q) begin
				if (gap_done) begin
					count_q     <= '0;
					receiving_q <= 1'b0;
					gap_q       <= '0;
				end else begin
					gap_q <= gap_next;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/ulars_queue.sv =====
// ----------------------------------------------------------------------------
// ulars_queue: event queue between front and back
// A small first-in first-out buffer of event words so that the receive front
// and the sender back can stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module ulars_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  ulars_pkg::link_evt_t push_evt,
	input  wire                  pop,
	output ulars_pkg::link_evt_t pop_evt,
	output logic                 full,
	output logic                 nonempty
);
	import ulars_pkg::*;

	link_evt_t              slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign full     = (count_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_evt  = slot_q[rd_ptr_q];

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_evt;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/ulars_back.sv =====
// ----------------------------------------------------------------------------
// ulars_back: stop-and-wait sender back end
// Steps the sender once per event word and registers the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module ulars_back #(
	parameter int TIMER_WIDTH = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  ulars_pkg::link_evt_t  evt,
	input  wire                   evt_ready,
	output logic                  evt_pop,
	input  wire [15:0]            guard_ticks,
	input  wire [15:0]            reply_timeout_ticks,
	output logic                  result_valid,
	input  wire                   result_stall,
	output ulars_pkg::out_word_t  result
);
	import ulars_pkg::*;

	localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

	step_t                  step_q;
	step_t                  step_next;
	logic [TIMER_WIDTH-1:0] timer_q;
	logic [TIMER_WIDTH-1:0] timer_next;
	logic [TIMER_WIDTH-1:0] timer_up;
	logic                   guard_done;
	logic                   reply_done;
	logic                   line_idle;
	logic                   send;
	logic                   done;
	logic                   valid_q;
	out_word_t              result_q;

	// An event is taken when the result register is free or being emptied.
	assign evt_pop      = evt_ready && (!valid_q || !result_stall);
	assign result_valid = valid_q;
	assign result       = result_q;

	// Timer advance and the two expiry tests.
	always_comb begin
		timer_up   = (timer_q == '1) ? timer_q : timer_q + 1'b1;
		guard_done = (CMP_W'(timer_up) >= CMP_W'(guard_ticks)) || (timer_up == '1);
		reply_done = (CMP_W'(timer_up) >= CMP_W'(reply_timeout_ticks)) || (timer_up == '1);
		line_idle  = !evt.tx_busy && !evt.receiving;
	end

	// Next step and timer.
	always_comb begin
		step_next  = step_q;
		timer_next = timer_q;
		if (evt.send_request) begin
			case (step_q)
				STEP_IDLE, STEP_WAIT: begin
					step_next  = line_idle ? STEP_GUARD : STEP_WAIT;
					timer_next = '0;
				end
				STEP_GUARD: begin
					if (guard_done) begin
						step_next  = line_idle ? STEP_SEND : STEP_WAIT;
						timer_next = '0;
					end else begin
						timer_next = timer_up;
					end
				end
				STEP_SEND: begin
					step_next  = STEP_DRAIN;
					timer_next = '0;
				end
				STEP_DRAIN: begin
					if (!evt.tx_busy) begin
						step_next  = STEP_REPLY;
						timer_next = '0;
					end
				end
				STEP_REPLY: begin
					if (evt.kind == KIND_ACK) begin
						step_next  = STEP_IDLE;
						timer_next = '0;
					end else if (evt.kind == KIND_NACK || reply_done) begin
						step_next  = STEP_SEND;
						timer_next = '0;
					end else begin
						timer_next = timer_up;
					end
				end
				default: begin
					step_next  = STEP_IDLE;
					timer_next = '0;
				end
			endcase
		end
	end

	// Sender outputs for this tick.
	always_comb begin
		send = 1'b0;
		done = 1'b0;
		if (evt.send_request) begin
			case (step_q)
				STEP_SEND:  send = 1'b1;
				STEP_REPLY: done = (evt.kind == KIND_ACK);
				default:    ;
			endcase
		end
	end

	// Sender state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_IDLE;
			timer_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (evt_pop) begin
				step_q  <= step_next;
				timer_q <= timer_next;
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Result word register.
	always_ff @(posedge clk) begin
		if (evt_pop) begin
			result_q.send_frame   <= send;
			result_q.send_done    <= done;
			result_q.frame_kind   <= evt.kind;
			result_q.frame_length <= evt.flen;
		end
	end

endmodule

`default_nettype wire

// ===== sv/uart_link_ack_retry_sequencer_core.sv =====
// Stop-and-wait link sequencer for a UART link. Each input word is one
// time-base tick, optionally carrying a received byte, and every word yields
// exactly one result word. A word is taken in every cycle while the event
// queue has room; the receive front and the sender back each complete one
// tick per cycle while the result side does not stall, so the sustained rate
// is one word per cycle. A four-entry event queue between the front and the
// back absorbs stalls on the result side before the input is stalled.
// Registers are to be written through the configuration port only while no
// word is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
// uart_link_ack_retry_sequencer_core: top level
// Receive front, event queue, sender back and configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_link_ack_retry_sequencer_core #(
	parameter int COUNT_WIDTH = 8,
	parameter int TIMER_WIDTH = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_stall,
	input  ulars_pkg::in_word_t  item,
	output logic                 result_valid,
	input  wire                  result_stall,
	output ulars_pkg::out_word_t result,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [1:0]            cfg_index,
	input  wire [15:0]           cfg_data
);
	import ulars_pkg::*;

	logic [15:0] gap_q;
	logic [15:0] guard_q;
	logic [15:0] timeout_q;
	logic        accept;
	logic        q_full;
	logic        q_nonempty;
	logic        q_pop;
	link_evt_t   front_evt;
	link_evt_t   back_evt;

	assign cfg_ready  = 1'b1;
	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q     <= GAP_RESET;
			guard_q   <= GUARD_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GAP:     gap_q     <= cfg_data;
				CFG_GUARD:   guard_q   <= cfg_data;
				CFG_TIMEOUT: timeout_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	ulars_front #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.gap_ticks (gap_q),
		.evt       (front_evt)
	);

	ulars_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_evt (front_evt),
		.pop      (q_pop),
		.pop_evt  (back_evt),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	ulars_back #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.evt                 (back_evt),
		.evt_ready           (q_nonempty),
		.evt_pop             (q_pop),
		.guard_ticks         (guard_q),
		.reply_timeout_ticks (timeout_q),
		.result_valid        (result_valid),
		.result_stall        (result_stall),
		.result              (result)
	);

	// A transmit order and a completion never fall in the same tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.send_frame && result.send_done))
		else $error("send_frame and send_done both set");

	// A tick without a classified frame reports zero length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.frame_kind == KIND_NONE) |-> (result.frame_length == 8'd0))
		else $error("frame_length set without a frame");

	// A new result only appears after the queue held an event.
	assert property (@(posedge clk) disable iff (!arst_n)
		!q_nonempty |=> !$rose(result_valid))
		else $error("result appeared from an empty queue");

endmodule

`default_nettype wire

// ===== verif/uart_link_ack_retry_sequencer_core_tb.sv =====
// ----------------------------------------------------------------------------
// uart_link_ack_retry_sequencer_core_tb: self-checking testbench
// Drives tick words with received bytes, transmitter state and send requests
// into the sequencer. A behavioral copy of the receive classifier and of the
// stop-and-wait sender predicts every result word. Directed rows follow an ACK
// frame, then random traffic of reply frames, other frames and idle stretches
// under several register settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module uart_link_ack_retry_sequencer_core_tb;
	import ulars_pkg::*;

	localparam int HANG_LIMIT = 2000;
	localparam int SHOW_LIMIT = 10;
	localparam int SEG_TICKS = 60;
	// Index with no register behind it; writes to it must change nothing.
	localparam logic [1:0] CFG_SPARE = 2'd3;

	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t want;
	} probe_t;

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	in_word_t   item;
	logic       result_valid;
	logic       result_stall = 1'b0;
	out_word_t  result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	// Behavioral copy of the block state and its registers.
	logic [7:0]  rx_head [4] = '{8'd0, 8'd0, 8'd0, 8'd0};
	logic [7:0]  rx_count = 8'd0;
	bit          rx_active = 1'b0;
	logic [15:0] rx_idle = 16'd0;
	step_t       tx_step = STEP_IDLE;
	logic [15:0] tx_timer = 16'd0;
	logic [15:0] gap_lim = GAP_RESET;
	logic [15:0] guard_lim = GUARD_RESET;
	logic [15:0] reply_lim = TIMEOUT_RESET;

	out_word_t due_words [$];
	int bad_count = 0;
	int quiet_cycles = 0;
	int calm_left = 0;
	int src_pct = 23;
	int sink_pct = 79;
	int tx_left = 0;
	int ticks_sent = 0;
	bit req_on = 1'b1;
	bit wander = 1'b0;

	// Directed rows under gap 1, guard 1, reply timeout 8.
	probe_t dir_rows [30] = '{
		'{'{1'b0, 8'h00, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, KIND_NONE, 8'd0}},
		'{'{1'b1, CHAR_A, 1'b0, 1'b1}, 1'b0, '0},
		'{'{1'b1, CHAR_C, 1'b0, 1'b1}, 1'b0, '0},
		'{'{1'b1, CHAR_K, 1'b0, 1'b1}, 1'b0, '0},
		'{'{1'b0, 8'h00, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, KIND_ACK, 8'd3}},
		'{'{1'b0, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
		'{'{1'b0, 8'h00, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b0, KIND_NONE, 8'd0}},
		'{'{1'b0, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
		'{'{1'b0, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
		'{'{1'b1, CHAR_N, 1'b0, 1'b1}, 1'b0, '0},
		'{'{1'b1, CHAR_A, 1'b0, 1'b1}, 1'b0, '0},
		'{'{1'b1, CHAR_C, 1'b0, 1'b1}, 1'b0, '0},
		'{'{1'b1, CHAR_K, 1'b0, 1'b1}, 1'b0, '0},
		'{'{1'b0, 8'h00, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, KIND_NACK, 8'd4}},
		'{'{1'b0, 8'h00, 1'b0, 1'b1}, 1'b1, '{1'b1, 1'b0, KIND_NONE, 8'd0}},
		'{'{1'b0, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
		'{'{1'b1, CHAR_A, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b1, CHAR_C, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b1, CHAR_K, 1'b0, 1'b1}, 1'b0, '0},
		'{'{1'b0, 8'h00, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b1, KIND_ACK, 8'd3}},
		'{'{1'b1, 8'hFF, 1'b1, 1'b0}, 1'b0, '0},
		'{'{1'b1, CHAR_W, 1'b1, 1'b0}, 1'b0, '0},
		'{'{1'b1, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b1, 8'hFF, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b1, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b1, 8'hFF, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b0, 8'hFF, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, KIND_NEW, 8'd6}},
		'{'{1'b1, CHAR_W, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b1, CHAR_W, 1'b0, 1'b0}, 1'b0, '0},
		'{'{1'b0, 8'h00, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, KIND_OTHER, 8'd2}}
	};

	uart_link_ack_retry_sequencer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Timers count up and hold at their top value.
	function automatic logic [15:0] bump(input logic [15:0] t);
		return (t == 16'hFFFF) ? t : t + 16'd1;
	endfunction

	// A held-at-top timer counts as expired whatever the limit.
	function automatic bit timed_out(input logic [15:0] t, input logic [15:0] lim);
		return (t >= lim) || (t == 16'hFFFF);
	endfunction

	// Kind of the frame held in the head bytes and the byte count.
	function automatic kind_t frame_kind_of();
		if (rx_count == 8'd3 && rx_head[0] == CHAR_A && rx_head[1] == CHAR_C &&
				rx_head[2] == CHAR_K)
			return KIND_ACK;
		if (rx_count == 8'd4 && rx_head[0] == CHAR_N && rx_head[1] == CHAR_A &&
				rx_head[2] == CHAR_C && rx_head[3] == CHAR_K)
			return KIND_NACK;
		if (rx_count > 8'd5 && rx_head[1] == CHAR_W)
			return KIND_NEW;
		return KIND_OTHER;
	endfunction

	// Advances the link by one tick and returns the result word it yields.
	function automatic out_word_t link_tick(input in_word_t w);
		out_word_t r;
		kind_t seen;
		bit line_free;
		r = '0;
		seen = KIND_NONE;

		// Receive side: count bytes, keep the head, classify after the gap.
		if (w.byte_valid) begin
			if (rx_count < 8'd4)
				rx_head[rx_count[1:0]] = w.byte_value;
			if (rx_count != 8'hFF)
				rx_count = rx_count + 8'd1;
			rx_active = 1'b1;
			rx_idle = 16'd0;
		end else if (rx_active) begin
			rx_idle = bump(rx_idle);
			if (timed_out(rx_idle, gap_lim)) begin
				seen = frame_kind_of();
				r.frame_kind = seen;
				r.frame_length = rx_count;
				rx_count = 8'd0;
				rx_active = 1'b0;
				rx_idle = 16'd0;
			end
		end

		// Sender: holds its step and timer while the request is absent.
		if (w.send_request) begin
			line_free = !w.tx_busy && !rx_active;
			case (tx_step)
				STEP_IDLE, STEP_WAIT: begin
					tx_timer = 16'd0;
					if (line_free)
						tx_step = STEP_GUARD;
					else
						tx_step = STEP_WAIT;
				end
				STEP_GUARD: begin
					tx_timer = bump(tx_timer);
					if (timed_out(tx_timer, guard_lim)) begin
						tx_timer = 16'd0;
						if (line_free)
							tx_step = STEP_SEND;
						else
							tx_step = STEP_WAIT;
					end
				end
				STEP_SEND: begin
					r.send_frame = 1'b1;
					tx_step = STEP_DRAIN;
					tx_timer = 16'd0;
				end
				STEP_DRAIN: begin
					if (!w.tx_busy) begin
						tx_step = STEP_REPLY;
						tx_timer = 16'd0;
					end
				end
				STEP_REPLY: begin
					tx_timer = bump(tx_timer);
					if (seen == KIND_ACK) begin
						r.send_done = 1'b1;
						tx_step = STEP_IDLE;
						tx_timer = 16'd0;
					end else if (seen == KIND_NACK || timed_out(tx_timer, reply_lim)) begin
						tx_step = STEP_SEND;
						tx_timer = 16'd0;
					end
				end
				default: begin
					tx_step = STEP_IDLE;
					tx_timer = 16'd0;
				end
			endcase
		end
		return r;
	endfunction

	function automatic void note_miss(input string what, input out_word_t want,
			input out_word_t got);
		bad_count++;
		if (bad_count <= SHOW_LIMIT)
			$display("%0t %s: expected send=%0b done=%0b kind=%0d len=%0d, got send=%0b done=%0b kind=%0d len=%0d",
				$realtime, what, want.send_frame, want.send_done, want.frame_kind,
				want.frame_length, got.send_frame, got.send_done, got.frame_kind,
				got.frame_length);
	endfunction

	// Hands one tick word to the block; called at a falling edge or just after
	// an acceptance, returns right after the word is taken.
	task automatic put_tick(input in_word_t w, input bit typed, input out_word_t want);
		out_word_t got;
		@(negedge clk);
		while (calm_left == 0 && $urandom_range(0, 99) < src_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (item_stall);
		got = link_tick(w);
		if (got.send_frame)
			tx_left = $urandom_range(0, 6);
		due_words.push_back(typed ? want : got);
	endtask

	// Builds one tick around an optional byte, with a transmitter that stays
	// busy for a few ticks after each ordered frame.
	task automatic emit(input bit bv, input logic [7:0] val);
		in_word_t w;
		w.byte_valid = bv;
		w.byte_value = bv ? val : 8'($urandom);
		if (wander) begin
			if (req_on)
				req_on = $urandom_range(0, 99) >= 3;
			else
				req_on = $urandom_range(0, 99) < 25;
		end
		w.send_request = req_on;
		w.tx_busy = (tx_left != 0) || (wander && $urandom_range(0, 99) < 3);
		if (tx_left != 0)
			tx_left--;
		ticks_sent++;
		put_tick(w, 1'b0, '0);
	endtask

	// At most one random frame (half replies, some damaged), then idle ticks.
	task automatic episode();
		logic [7:0] fb [$];
		int pick, n, sp, smax, quiet;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			fb = '{CHAR_A, CHAR_C, CHAR_K};
		end else if (pick < 50) begin
			fb = '{CHAR_N, CHAR_A, CHAR_C, CHAR_K};
		end else if (pick < 65) begin
			n = $urandom_range(5, 10);
			repeat (n) fb.push_back(8'($urandom));
			fb[1] = CHAR_W;
		end else if (pick < 90) begin
			n = $urandom_range(1, 8);
			repeat (n) begin
				case ($urandom_range(0, 5))
					0: fb.push_back(CHAR_A);
					1: fb.push_back(CHAR_C);
					2: fb.push_back(CHAR_K);
					3: fb.push_back(CHAR_N);
					4: fb.push_back(CHAR_W);
					default: fb.push_back(8'($urandom));
				endcase
			end
		end else if (pick < 93) begin
			// Long frame that can drive the byte count into saturation.
			n = $urandom_range(250, 300);
			repeat (n) fb.push_back(8'($urandom));
		end

		// Damage some reply frames: a flipped bit, an extra or a missing byte.
		if (pick < 50) begin
			n = $urandom_range(0, 99);
			sp = $urandom_range(0, fb.size() - 1);
			if (n < 10)
				fb[sp] = fb[sp] ^ 8'(1 << $urandom_range(0, 7));
			else if (n < 14)
				fb.push_back(8'($urandom));
			else if (n < 18)
				void'(fb.pop_back());
		end

		smax = (gap_lim > 16'd3) ? 2 : ((gap_lim == 16'd0) ? 0 : int'(gap_lim) - 1);
		foreach (fb[k]) begin
			if (k > 0) begin
				sp = $urandom_range(0, smax);
				if ($urandom_range(0, 99) < 4)
					sp = int'(gap_lim) + 1;
				repeat (sp) emit(1'b0, 8'h00);
			end
			emit(1'b1, fb[k]);
		end
		quiet = int'(gap_lim) + $urandom_range(0, int'(guard_lim) + 6);
		repeat (quiet) emit(1'b0, 8'h00);
	endtask

	// Writes all registers once the block has drained, plus the unmapped index.
	task automatic set_regs(input logic [15:0] gap, input logic [15:0] guard,
			input logic [15:0] reply);
		logic [1:0] idx_list [4];
		logic [15:0] val_list [4];
		idx_list = '{CFG_GAP, CFG_GUARD, CFG_TIMEOUT, CFG_SPARE};
		val_list = '{gap, guard, reply, 16'($urandom)};
		@(negedge clk);
		item_valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
		for (int k = 0; k < 4; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx_list[k];
			cfg_data <= val_list[k];
			do @(posedge clk); while (!cfg_ready);
			case (idx_list[k])
				CFG_GAP: gap_lim = val_list[k];
				CFG_GUARD: guard_lim = val_list[k];
				CFG_TIMEOUT: reply_lim = val_list[k];
				default: ;
			endcase
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Receiver stalls, with occasional calm stretches shared by both sides.
	always @(negedge clk) begin
		if (calm_left != 0)
			calm_left <= calm_left - 1;
		else if ($urandom_range(0, 99) < 2)
			calm_left <= $urandom_range(20, 80);
		result_stall <= (calm_left == 0) && ($urandom_range(0, 99) < sink_pct);
	end

	// Compare each taken result word with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (due_words.size() == 0) begin
				note_miss("unexpected word", '0, result);
			end else begin
				if (result.send_frame !== due_words[0].send_frame ||
						result.send_done !== due_words[0].send_done ||
						result.frame_kind !== due_words[0].frame_kind ||
						result.frame_length !== due_words[0].frame_length)
					note_miss("mismatch", due_words[0], result);
				void'(due_words.pop_front());
			end
		end
	end

	// Hang detection: too many cycles with no handshake on any channel.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] ack_text [3];
		int mark;
		ack_text = '{CHAR_A, CHAR_C, CHAR_K};
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_GAP;
		cfg_data = 16'd0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Reset register values: an ACK frame that the default gap closes,
		// with the sender entering its guard time afterwards.
		foreach (ack_text[k]) emit(1'b1, ack_text[k]);
		repeat (302) emit(1'b0, 8'h00);

		// Directed rows.
		set_regs(16'd1, 16'd1, 16'd8);
		foreach (dir_rows[k])
			put_tick(dir_rows[k].w, dir_rows[k].typed, dir_rows[k].want);

		// Random traffic over several settings and idle patterns.
		wander = 1'b1;
		for (int seg = 0; seg < 6; seg++) begin
			case (seg)
				0: set_regs(16'd4, 16'd6, 16'd60);
				1: set_regs(16'd1, 16'd1, 16'd1);
				2: set_regs(16'd0, 16'd0, 16'd0);
				3: set_regs(16'd7, 16'd3, 16'd30);
				4: set_regs(16'd2, 16'd10, 16'd100);
				default: set_regs(16'($urandom_range(1, 8)), 16'($urandom_range(0, 12)),
					16'($urandom_range(5, 80)));
			endcase
			src_pct = (seg < 2) ? 23 : ((seg < 4) ? 79 : 0);
			sink_pct = (seg < 2) ? 79 : ((seg < 4) ? 23 : 0);
			mark = ticks_sent;
			while (ticks_sent - mark < SEG_TICKS)
				episode();
		end

		// Largest register values: one frame and a quiet stretch with a steady
		// request; neither the gap nor the guard runs out here.
		wander = 1'b0;
		req_on = 1'b1;
		set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
		foreach (ack_text[k]) emit(1'b1, ack_text[k]);
		repeat (40) emit(1'b0, 8'h00);

		@(negedge clk);
		item_valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (bad_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
